// ----- hdl/sffe_pkg.sv -----
// ---------------------------------------------------------------------------
// sffe_pkg: shared definitions for the scan format field extractor
// Widths, op/result/conversion/phase codes, register indexes, byte constants.
// ---------------------------------------------------------------------------
`default_nettype none

package sffe_pkg;

    localparam int MAX_CONVERSIONS = 8;
    localparam int VALUE_WIDTH     = 32;
    localparam int SLOT_W          = $clog2(MAX_CONVERSIONS + 1);
    localparam int SLOT_OUT_W      = 3;
    localparam int CODE_IDX_W      = $clog2(2 * MAX_CONVERSIONS);
    localparam int CODES_W         = 2 * MAX_CONVERSIONS;
    localparam int LEN_W           = 4;
    localparam int COUNT_W         = 4;
    localparam int KIND_W          = 3;
    localparam int OP_W            = 2;
    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 16;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_FIELDS_W    = SLOT_OUT_W + VALUE_WIDTH + COUNT_W;
    localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    // input operations
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OP_W-1:0] OP_EOF   = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STR_BYTE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STR_END  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd4;

    // conversion codes
    localparam logic [1:0] CONV_CHAR  = 2'd0;
    localparam logic [1:0] CONV_INT   = 2'd1;
    localparam logic [1:0] CONV_STR   = 2'd2;
    localparam logic [1:0] CONV_UNSUP = 2'd3;

    // field phase
    localparam logic [1:0] PH_SKIP  = 2'd0;
    localparam logic [1:0] PH_MINUS = 2'd1;
    localparam logic [1:0] PH_FIELD = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_CODES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_LENGTH = 4'd1;

    // byte constants
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

endpackage

`default_nettype wire

// ----- hdl/scan_format_field_extractor.sv -----
// ---------------------------------------------------------------------------
// scan_format_field_extractor
// Runs a configured list of char / integer / string conversions over a
// byte stream and returns one item per field, string byte and scan end.
// ---------------------------------------------------------------------------
// One input item (start, byte or end of input) is taken when s_tready is
// high, which is only while the sequencer is idle. The item then runs
// through a small sequencer: an item with no result goes straight to the
// flush, a whitespace byte or a minus is fed to the current slot, a digit
// also takes two passes of the shared 32-bit adder (first acc*10 from two
// shifted copies, then + digit), a conversion that the symbol is passed on
// from adds its feed and the opening of the next slot, and a finished
// integer takes one more pass of the adder to apply its sign and one step
// to hand it on. The longest item is an end of input that closes an
// integer and then seven strings. Results leave through a one-deep
// staging register and the output register, so the tlast of the final
// result of an item is known before it is shown; a stalled m_tready holds
// the sequencer while a result is staged, save in adder states. Registers are
// written on the cfg port at any time; they take effect at the next decision
// of the sequencer. A byte that ends a field with the scan then finished is
// kept and fed to the next scan start; bytes while no scan runs are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module scan_format_field_extractor
    import sffe_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,

    // input items
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire [IN_TDATA_W-1:0]   s_tdata,    // [7:0] data_byte
    input  wire [OP_W-1:0]         s_tuser,    // [1:0] op

    // result items
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // [2:0] slot, [34:3] value,
                                               // [38:35] conversions, pad 0
    output logic [KIND_W-1:0]      m_tuser,    // [2:0] kind
    output logic                   m_tlast,    // last result of the item

    // register writes
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BEGIN = 4'd1;  // open a conversion slot
    localparam logic [3:0] ST_FEED  = 4'd2;  // offer the symbol to the slot
    localparam logic [3:0] ST_MUL   = 4'd3;  // acc * 10
    localparam logic [3:0] ST_ADD   = 4'd4;  // acc + digit
    localparam logic [3:0] ST_NEG   = 4'd5;  // apply sign
    localparam logic [3:0] ST_SINT  = 4'd6;  // emit finished integer
    localparam logic [3:0] ST_FLUSH = 4'd7;  // release staged result as last

    logic [3:0]             state_reg, state_next;

    // configuration
    logic [CODES_W-1:0]     codes_reg, codes_next;
    logic [LEN_W-1:0]       length_reg, length_next;

    // scan state
    logic                   active_reg, active_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [COUNT_W-1:0]     succ_reg, succ_next;
    logic [1:0]             phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0]      held_byte_reg, held_byte_next;

    // current symbol and item context
    logic [BYTE_W-1:0]      sym_byte_reg, sym_byte_next;
    logic                   sym_eof_reg, sym_eof_next;
    logic                   start_ctx_reg, start_ctx_next;
    logic                   cons_reg, cons_next;

    // staged result
    logic                   pend_valid_reg, pend_valid_next;
    logic [SLOT_OUT_W-1:0]  pend_slot_reg, pend_slot_next;
    logic [KIND_W-1:0]      pend_kind_reg, pend_kind_next;
    logic [VALUE_WIDTH-1:0] pend_value_reg, pend_value_next;
    logic [COUNT_W-1:0]     pend_conv_reg, pend_conv_next;

    // output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [SLOT_OUT_W-1:0]  m_slot_reg, m_slot_next;
    logic [KIND_W-1:0]      m_kind_reg, m_kind_next;
    logic [VALUE_WIDTH-1:0] m_value_reg, m_value_next;
    logic [COUNT_W-1:0]     m_conv_reg, m_conv_next;

    // shared adder
    logic [VALUE_WIDTH-1:0] add_a, add_b, add_sum;
    logic                   add_cin;

    // emit request
    logic                   emit;
    logic [SLOT_OUT_W-1:0]  e_slot;
    logic [KIND_W-1:0]      e_kind;
    logic [VALUE_WIDTH-1:0] e_value;
    logic [COUNT_W-1:0]     e_conv;

    logic                   out_free, emit_ok;
    logic [1:0]             cur_code;
    logic [LEN_W-1:0]       len_eff;
    logic                   slot_end;
    logic                   is_sp, is_dig, is_minus;
    logic                   s_accept;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = OUT_TDATA_W'({m_conv_reg, m_value_reg, m_slot_reg});

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_ok  = !pend_valid_reg || out_free;

    // slots past the list read as char code
    assign cur_code = (slot_reg >= SLOT_W'(MAX_CONVERSIONS)) ? CONV_CHAR :
                      codes_reg[{slot_reg[SLOT_W-2:0], 1'b0} +: 2];
    assign len_eff  = (length_reg > LEN_W'(MAX_CONVERSIONS)) ?
                      LEN_W'(MAX_CONVERSIONS) : length_reg;
    assign slot_end = (LEN_W'(slot_reg) >= len_eff) || (cur_code == CONV_UNSUP);

    assign is_sp    = !sym_eof_reg &&
                      (((sym_byte_reg >= CH_TAB) && (sym_byte_reg <= CH_CR)) ||
                       (sym_byte_reg == CH_SPACE));
    assign is_dig   = !sym_eof_reg && (sym_byte_reg >= CH_ZERO) &&
                      (sym_byte_reg <= CH_NINE);
    assign is_minus = !sym_eof_reg && (sym_byte_reg == CH_MINUS);

    // shared adder: acc*10 = acc*8 + acc*2, then + digit; sign by ~acc + 1
    always_comb begin
        add_a   = acc_reg;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            ST_MUL: begin
                add_a = acc_reg << 3;
                add_b = acc_reg << 1;
            end
            ST_ADD: begin
                add_b = VALUE_WIDTH'(sym_byte_reg[3:0]);
            end
            ST_NEG: begin
                add_a   = neg_reg ? ~acc_reg : acc_reg;
                add_cin = neg_reg;
            end
            default: begin
                add_a = acc_reg;
            end
        endcase
    end
    assign add_sum = add_a + add_b + VALUE_WIDTH'(add_cin);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        active_next     = active_reg;
        slot_next       = slot_reg;
        succ_next       = succ_reg;
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        sym_byte_next   = sym_byte_reg;
        sym_eof_next    = sym_eof_reg;
        start_ctx_next  = start_ctx_reg;
        cons_next       = cons_reg;
        emit            = 1'b0;
        e_slot          = slot_reg[SLOT_OUT_W-1:0];
        e_kind          = KIND_DONE;
        e_value         = '0;
        e_conv          = succ_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sym_byte_next  = s_tdata[BYTE_W-1:0];
                    start_ctx_next = 1'b0;
                    state_next     = ST_FLUSH;
                    case (s_tuser)
                        OP_START: begin
                            active_next    = 1'b1;
                            slot_next      = '0;
                            succ_next      = '0;
                            start_ctx_next = 1'b1;
                            state_next     = ST_BEGIN;
                        end
                        OP_BYTE: begin
                            sym_eof_next = 1'b0;
                            if (active_reg)
                                state_next = ST_FEED;
                        end
                        OP_EOF: begin
                            sym_eof_next = 1'b1;
                            if (active_reg)
                                state_next = ST_FEED;
                        end
                        default: begin
                            state_next = ST_FLUSH;
                        end
                    endcase
                end
            end

            ST_BEGIN: begin
                if (emit_ok) begin
                    phase_next = PH_SKIP;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    if (slot_end) begin
                        emit        = 1'b1;
                        e_slot      = '0;
                        e_kind      = KIND_DONE;
                        active_next = 1'b0;
                    end
                    if (start_ctx_reg) begin
                        // fresh scan: hand over a byte kept from the last one
                        start_ctx_next = 1'b0;
                        if (!slot_end && held_valid_reg) begin
                            held_valid_next = 1'b0;
                            sym_byte_next   = held_byte_reg;
                            sym_eof_next    = 1'b0;
                            state_next      = ST_FEED;
                        end else begin
                            state_next = ST_FLUSH;
                        end
                    end else if (cons_reg) begin
                        state_next = ST_FLUSH;
                    end else if (!slot_end) begin
                        state_next = ST_FEED;
                    end else begin
                        if (!sym_eof_reg) begin
                            held_valid_next = 1'b1;
                            held_byte_next  = sym_byte_reg;
                        end
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FEED: begin
                if (emit_ok) begin
                    case (cur_code)
                        CONV_CHAR: begin
                            if (sym_eof_reg) begin
                                emit        = 1'b1;
                                e_slot      = '0;
                                e_kind      = KIND_DONE;
                                active_next = 1'b0;
                                state_next  = ST_FLUSH;
                            end else begin
                                emit       = 1'b1;
                                e_kind     = KIND_CHAR;
                                e_value    = VALUE_WIDTH'(sym_byte_reg);
                                e_conv     = succ_reg + 1'b1;
                                succ_next  = succ_reg + 1'b1;
                                slot_next  = slot_reg + 1'b1;
                                cons_next  = 1'b1;
                                state_next = ST_BEGIN;
                            end
                        end
                        CONV_INT: begin
                            if ((phase_reg == PH_SKIP) && is_sp) begin
                                state_next = ST_FLUSH;
                            end else if ((phase_reg == PH_SKIP) && is_minus) begin
                                neg_next   = 1'b1;
                                phase_next = PH_MINUS;
                                state_next = ST_FLUSH;
                            end else if (is_dig) begin
                                phase_next = PH_FIELD;
                                state_next = ST_MUL;
                            end else if (phase_reg == PH_FIELD) begin
                                state_next = ST_NEG;
                            end else begin
                                // no digits: scan fails, byte kept
                                emit        = 1'b1;
                                e_slot      = '0;
                                e_kind      = KIND_DONE;
                                active_next = 1'b0;
                                if (!sym_eof_reg) begin
                                    held_valid_next = 1'b1;
                                    held_byte_next  = sym_byte_reg;
                                end
                                state_next = ST_FLUSH;
                            end
                        end
                        CONV_STR: begin
                            if (sym_eof_reg || (is_sp && (phase_reg == PH_FIELD))) begin
                                emit       = 1'b1;
                                e_kind     = KIND_STR_END;
                                e_conv     = succ_reg + 1'b1;
                                succ_next  = succ_reg + 1'b1;
                                slot_next  = slot_reg + 1'b1;
                                cons_next  = 1'b0;
                                state_next = ST_BEGIN;
                            end else if (is_sp) begin
                                state_next = ST_FLUSH;
                            end else begin
                                emit       = 1'b1;
                                e_kind     = KIND_STR_BYTE;
                                e_value    = VALUE_WIDTH'(sym_byte_reg);
                                phase_next = PH_FIELD;
                                state_next = ST_FLUSH;
                            end
                        end
                        default: begin
                            emit        = 1'b1;
                            e_slot      = '0;
                            e_kind      = KIND_DONE;
                            active_next = 1'b0;
                            if (!sym_eof_reg) begin
                                held_valid_next = 1'b1;
                                held_byte_next  = sym_byte_reg;
                            end
                            state_next = ST_FLUSH;
                        end
                    endcase
                end
            end

            ST_MUL: begin
                acc_next   = add_sum;
                state_next = ST_ADD;
            end

            ST_ADD: begin
                acc_next   = add_sum;
                state_next = ST_FLUSH;
            end

            ST_NEG: begin
                acc_next   = add_sum;
                state_next = ST_SINT;
            end

            ST_SINT: begin
                if (emit_ok) begin
                    emit       = 1'b1;
                    e_kind     = KIND_INT;
                    e_value    = acc_reg;
                    e_conv     = succ_reg + 1'b1;
                    succ_next  = succ_reg + 1'b1;
                    slot_next  = slot_reg + 1'b1;
                    cons_next  = 1'b0;
                    state_next = ST_BEGIN;
                end
            end

            ST_FLUSH: begin
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // staging and output registers
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_kind_next  = pend_kind_reg;
        pend_value_next = pend_value_reg;
        pend_conv_next  = pend_conv_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tlast_next    = m_tlast_reg;
        m_slot_next     = m_slot_reg;
        m_kind_next     = m_kind_reg;
        m_value_next    = m_value_reg;
        m_conv_next     = m_conv_reg;

        if ((emit || (state_reg == ST_FLUSH)) && pend_valid_reg && out_free) begin
            // a further result means the staged one is not last
            m_tvalid_next   = 1'b1;
            m_tlast_next    = !emit;
            m_slot_next     = pend_slot_reg;
            m_kind_next     = pend_kind_reg;
            m_value_next    = pend_value_reg;
            m_conv_next     = pend_conv_reg;
            pend_valid_next = 1'b0;
        end
        if (emit) begin
            pend_valid_next = 1'b1;
            pend_slot_next  = e_slot;
            pend_kind_next  = e_kind;
            pend_value_next = e_value;
            pend_conv_next  = e_conv;
        end
    end

    // register writes
    always_comb begin
        codes_next  = codes_reg;
        length_next = length_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FORMAT_CODES:  codes_next  = cfg_data[CODES_W-1:0];
                REG_FORMAT_LENGTH: length_next = cfg_data[LEN_W-1:0];
                default: begin
                    codes_next = codes_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            codes_reg      <= '0;
            length_reg     <= '0;
            active_reg     <= 1'b0;
            slot_reg       <= '0;
            succ_reg       <= '0;
            phase_reg      <= PH_SKIP;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
            start_ctx_reg  <= 1'b0;
            cons_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            codes_reg      <= codes_next;
            length_reg     <= length_next;
            active_reg     <= active_next;
            slot_reg       <= slot_next;
            succ_reg       <= succ_next;
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
            start_ctx_reg  <= start_ctx_next;
            cons_reg       <= cons_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_byte_reg   <= sym_byte_next;
        sym_eof_reg    <= sym_eof_next;
        pend_slot_reg  <= pend_slot_next;
        pend_kind_reg  <= pend_kind_next;
        pend_value_reg <= pend_value_next;
        pend_conv_reg  <= pend_conv_next;
        m_tlast_reg    <= m_tlast_next;
        m_slot_reg     <= m_slot_next;
        m_kind_reg     <= m_kind_next;
        m_value_reg    <= m_value_next;
        m_conv_reg     <= m_conv_next;
    end

    // checks
    a_idle_no_staged: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("staged result left behind at item end");

    a_count_tracks_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        succ_reg == COUNT_W'(slot_reg))
        else $error("success count and slot index disagree");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(MAX_CONVERSIONS))
        else $error("slot index past conversion list");

    a_feed_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FEED || state_reg == ST_MUL || state_reg == ST_SINT)
        |-> active_reg)
        else $error("symbol offered with no scan running");

    a_done_ends_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && e_kind == KIND_DONE) |=> !active_reg)
        else $error("scan still running after done");

endmodule

`default_nettype wire
